@@ sv/dbnc_pkg.sv @@
// Shared types and constants for the multi-channel switch debouncer.
// Holds the per-switch state word, the phase encoding and register indexes.
// No dependencies.
`default_nettype none

package dbnc_pkg;

    localparam int IDX_W   = 4;
    localparam int COUNT_W = 5;
    localparam int LEVEL_W = 8;
    localparam int RUN_W   = 8;

    localparam logic [COUNT_W-1:0] SWITCH_COUNT_RST = 5'd16;
    localparam logic [LEVEL_W-1:0] STABLE_LEVEL_RST = 8'd5;
    localparam logic [RUN_W-1:0]   RUN_MAX          = 8'hFF;

    localparam logic REG_SWITCH_COUNT = 1'b0;
    localparam logic REG_STABLE_LEVEL = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    typedef enum logic [1:0] {
        PH_RELEASED = 2'd0,
        PH_BOUNCING = 2'd1,
        PH_PRESSED  = 2'd2
    } phase_t;

    // All-zero word is the reset state: released, counters clear, stable 0.
    typedef struct packed {
        phase_t           phase;
        logic [RUN_W-1:0] pressed_run;
        logic [RUN_W-1:0] released_run;
        logic             stable_value;
    } sw_state_t;

    localparam int STATE_W = $bits(sw_state_t);

endpackage

`default_nettype wire

@@ sv/multi_channel_switch_debouncer_core.sv @@
// Multi-channel switch debouncer: per-switch state held in one synchronous RAM.
// Pipeline: an accepted item sits in the stage 1 register while its RAM read completes, then
// moves into the output register when the output is free. Throughput: one item per cycle
// unless result_stall holds the output; a same-switch sample right behind is forwarded.
// Reset: all switches released with clear counters (per-entry valid bits, no clearing
// pass), switch_count = 16, stable_level = 5. Depends on dbnc_pkg, dbnc_ram, dbnc_update.
`default_nettype none

module multi_channel_switch_debouncer_core
    import dbnc_pkg::*;
#(
    parameter int MAX_SWITCHES = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             sample_valid,
    output logic                  sample_stall,
    input  wire logic [IDX_W-1:0] switch_index,
    input  wire logic             pin_pressed,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output logic                  status,
    output logic                  debounced_pressed,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [2:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic      [31:0]      prdata,
    output logic                  pready
);

    localparam int ADDR_W = (MAX_SWITCHES > 1) ? $clog2(MAX_SWITCHES) : 1;

    // Configuration registers.
    logic [COUNT_W-1:0] switch_count_reg;
    logic [LEVEL_W-1:0] stable_level_reg;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            switch_count_reg <= SWITCH_COUNT_RST;
            stable_level_reg <= STABLE_LEVEL_RST;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_SWITCH_COUNT)
            begin
                switch_count_reg <= pwdata[COUNT_W-1:0];
            end
            else
            begin
                stable_level_reg <= pwdata[LEVEL_W-1:0];
            end
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_SWITCH_COUNT: prdata = {{(32-COUNT_W){1'b0}}, switch_count_reg};
            REG_STABLE_LEVEL: prdata = {{(32-LEVEL_W){1'b0}}, stable_level_reg};
            default:          prdata = '0;
        endcase
    end

    // Pipeline control.
    logic s1_valid_reg;
    logic s1_advance;
    logic out_free;
    logic accept;

    assign out_free     = !result_valid || !result_stall;
    assign s1_advance   = s1_valid_reg && out_free;
    assign accept       = sample_valid && (!s1_valid_reg || s1_advance);
    assign sample_stall = s1_valid_reg && !s1_advance;

    // Read address for the incoming item.
    logic [IDX_W+ADDR_W-1:0] in_addr_ext;
    logic [ADDR_W-1:0]       in_addr;

    assign in_addr_ext = {{ADDR_W{1'b0}}, switch_index};
    assign in_addr     = in_addr_ext[ADDR_W-1:0];

    // Stage 1 item.
    logic [IDX_W-1:0] s1_idx_reg;
    logic             s1_pin_reg;
    logic [IDX_W+ADDR_W-1:0] s1_addr_ext;
    logic [ADDR_W-1:0]       s1_addr;

    assign s1_addr_ext = {{ADDR_W{1'b0}}, s1_idx_reg};
    assign s1_addr     = s1_addr_ext[ADDR_W-1:0];

    // Write port, per-entry valid bits and forwarding of a same-cycle write.
    logic                    wr_en;
    sw_state_t               wr_data;
    logic [MAX_SWITCHES-1:0] valid_reg;
    logic                    fwd_valid_reg;
    logic [ADDR_W-1:0]       fwd_addr_reg;
    sw_state_t               fwd_data_reg;
    logic [STATE_W-1:0]      ram_q;

    dbnc_ram #(
        .WIDTH (STATE_W),
        .DEPTH (MAX_SWITCHES)
    ) u_state_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s1_addr),
        .wdata (wr_data),
        .re    (accept),
        .raddr (in_addr),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            valid_reg     <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (wr_en)
            begin
                valid_reg[s1_addr] <= 1'b1;
            end
            // The write made in the cycle an item's read is issued is missed by that read.
            if (accept)
            begin
                fwd_valid_reg <= wr_en;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_idx_reg   <= switch_index;
            s1_pin_reg   <= pin_pressed;
            fwd_addr_reg <= s1_addr;
            fwd_data_reg <= wr_data;
        end
    end

    // Resolve the current state of the stage 1 switch.
    sw_state_t cur_state;
    sw_state_t nxt_state;
    logic      cur_value;
    logic      in_range;

    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_addr))
        begin
            cur_state = fwd_data_reg;
        end
        else if (valid_reg[s1_addr])
        begin
            cur_state = sw_state_t'(ram_q);
        end
        else
        begin
            cur_state = '0;
        end
    end

    assign in_range = ({1'b0, s1_idx_reg} < switch_count_reg)
                   && (32'(s1_idx_reg) < MAX_SWITCHES);

    dbnc_update u_update (
        .cur   (cur_state),
        .pin   (s1_pin_reg),
        .level (stable_level_reg),
        .nxt   (nxt_state),
        .value (cur_value)
    );

    assign wr_en   = s1_advance && in_range;
    assign wr_data = nxt_state;

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid <= 1'b0;
        end
        else if (out_free)
        begin
            result_valid <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            status            <= in_range ? STATUS_OK : STATUS_RANGE;
            debounced_pressed <= in_range && cur_value;
        end
    end

endmodule

`default_nettype wire

@@ sv/dbnc_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read.
// A read of an address written in the same cycle returns the old contents.
// No dependencies.
`default_nettype none

module dbnc_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ sv/dbnc_update.sv @@
// Per-switch debounce state update: next phase, run counters and output value.
// Depends on dbnc_pkg.
`default_nettype none

module dbnc_update
    import dbnc_pkg::*;
(
    input  wire sw_state_t          cur,
    input  wire logic               pin,
    input  wire logic [LEVEL_W-1:0] level,
    output sw_state_t               nxt,
    output logic                    value
);

    logic [RUN_W-1:0] pr_bump;
    logic [RUN_W-1:0] rr_bump;

    // Run counters saturate at their top value.
    assign pr_bump = (cur.pressed_run == RUN_MAX) ? cur.pressed_run : cur.pressed_run + 1'b1;
    assign rr_bump = (cur.released_run == RUN_MAX) ? cur.released_run : cur.released_run + 1'b1;

    always_comb
    begin
        nxt = cur;
        case (cur.phase)
            PH_BOUNCING:
            begin
                if (pin)
                begin
                    nxt.pressed_run  = pr_bump;
                    nxt.released_run = '0;
                    if (pr_bump >= level)
                    begin
                        nxt.phase       = PH_PRESSED;
                        nxt.pressed_run = '0;
                    end
                end
                else
                begin
                    nxt.released_run = rr_bump;
                    nxt.pressed_run  = '0;
                    if (rr_bump >= level)
                    begin
                        nxt.phase        = PH_RELEASED;
                        nxt.released_run = '0;
                    end
                end
            end
            PH_PRESSED:
            begin
                nxt.stable_value = 1'b1;
                if (!pin)
                begin
                    nxt.phase = PH_BOUNCING;
                end
            end
            default:
            begin
                // The unused code behaves like released.
                nxt.stable_value = 1'b0;
                nxt.phase        = pin ? PH_BOUNCING : PH_RELEASED;
            end
        endcase
    end

    always_comb
    begin
        case (cur.phase)
            PH_BOUNCING: value = cur.stable_value;
            PH_PRESSED:  value = 1'b1;
            default:     value = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

@@ dv/tb_multi_channel_switch_debouncer_core.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for multi_channel_switch_debouncer_core: directed and random
// pin samples, register writes over the APB-style port, randomized idling and stalls.
// Depends on dbnc_pkg and the debouncer RTL.

module tb_multi_channel_switch_debouncer_core;
    import dbnc_pkg::*;

    localparam int NUM_SW      = 16;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic range_err;
        logic level;
    } debounce_out_t;

    // Tracks the per-switch debounce state and the outputs still owed by the block.
    class debounce_tracker;
        phase_t             sw_phase    [NUM_SW];
        logic [RUN_W-1:0]   press_cnt   [NUM_SW];
        logic [RUN_W-1:0]   release_cnt [NUM_SW];
        logic               held        [NUM_SW];
        logic [COUNT_W-1:0] num_switches;
        logic [LEVEL_W-1:0] commit_level;
        debounce_out_t      owed[$];
        int unsigned        mismatches;

        function new();
            for (int k = 0; k < NUM_SW; k++)
            begin
                sw_phase[k]    = PH_RELEASED;
                press_cnt[k]   = '0;
                release_cnt[k] = '0;
                held[k]        = 1'b0;
            end
            num_switches = SWITCH_COUNT_RST;
            commit_level = STABLE_LEVEL_RST;
            mismatches   = 0;
        endfunction

        function logic [RUN_W-1:0] bump(logic [RUN_W-1:0] v);
            return (v == RUN_MAX) ? v : v + 1'b1;
        endfunction

        function void accept_sample(logic [IDX_W-1:0] idx, logic pin);
            debounce_out_t o;
            o.range_err = STATUS_OK;
            o.level     = 1'b0;
            if ({1'b0, idx} >= num_switches)
            begin
                o.range_err = STATUS_RANGE;
            end
            else
            begin
                case (sw_phase[idx])
                    PH_BOUNCING:
                    begin
                        o.level = held[idx];
                        if (pin)
                        begin
                            press_cnt[idx]   = bump(press_cnt[idx]);
                            release_cnt[idx] = '0;
                            if (press_cnt[idx] >= commit_level)
                            begin
                                sw_phase[idx]  = PH_PRESSED;
                                press_cnt[idx] = '0;
                            end
                        end
                        else
                        begin
                            release_cnt[idx] = bump(release_cnt[idx]);
                            press_cnt[idx]   = '0;
                            if (release_cnt[idx] >= commit_level)
                            begin
                                sw_phase[idx]    = PH_RELEASED;
                                release_cnt[idx] = '0;
                            end
                        end
                    end
                    PH_PRESSED:
                    begin
                        held[idx] = 1'b1;
                        o.level   = 1'b1;
                        if (!pin)
                            sw_phase[idx] = PH_BOUNCING;
                    end
                    default:
                    begin
                        held[idx]     = 1'b0;
                        sw_phase[idx] = pin ? PH_BOUNCING : PH_RELEASED;
                    end
                endcase
            end
            owed.push_back(o);
        endfunction

        function void check_output(logic st, logic dp);
            debounce_out_t want;
            if (owed.size() == 0)
            begin
                $display("%0t: unexpected result: status %0b debounced_pressed %0b",
                         $time, st, dp);
                mismatches++;
                return;
            end
            want = owed.pop_front();
            if (st !== want.range_err)
            begin
                $display("%0t: status expected %0b actual %0b", $time, want.range_err, st);
                mismatches++;
            end
            if (dp !== want.level)
            begin
                $display("%0t: debounced_pressed expected %0b actual %0b",
                         $time, want.level, dp);
                mismatches++;
            end
        endfunction
    endclass

    logic             clk               = 1'b0;
    logic             rst_n             = 1'b0;
    logic             sample_valid      = 1'b0;
    logic             sample_stall;
    logic [IDX_W-1:0] switch_index      = '0;
    logic             pin_pressed       = 1'b0;
    logic             result_valid;
    logic             result_stall      = 1'b0;
    logic             status;
    logic             debounced_pressed;
    logic             psel              = 1'b0;
    logic             penable           = 1'b0;
    logic             pwrite            = 1'b0;
    logic [2:0]       paddr             = '0;
    logic [31:0]      pwdata            = '0;
    logic [31:0]      prdata;
    logic             pready;

    debounce_tracker  tracker;
    int               gap_pct   = 0;
    int               stall_pct = 0;
    int unsigned      hold_left = 0;
    int unsigned      cycles    = 0;

    multi_channel_switch_debouncer_core #(
        .MAX_SWITCHES(NUM_SW)
    ) u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .sample_valid     (sample_valid),
        .sample_stall     (sample_stall),
        .switch_index     (switch_index),
        .pin_pressed      (pin_pressed),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .status           (status),
        .debounced_pressed(debounced_pressed),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Result side: check every accepted result, then pick the stall for the next cycle.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            tracker.check_output(status, debounced_pressed);
        result_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
    end

    task automatic send_sample(input logic [IDX_W-1:0] idx, input logic pin);
        while ($urandom_range(99) < gap_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        switch_index <= idx;
        pin_pressed  <= pin;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        tracker.accept_sample(idx, pin);
    endtask

    task automatic write_reg(input logic sel, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Registers change only once every owed result is back and the pipeline has emptied.
    task automatic configure(input logic [COUNT_W-1:0] count, input logic [LEVEL_W-1:0] lvl);
        sample_valid <= 1'b0;
        while (tracker.owed.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        write_reg(REG_SWITCH_COUNT, {27'd0, count});
        write_reg(REG_STABLE_LEVEL, {24'd0, lvl});
        tracker.num_switches = count;
        tracker.commit_level = lvl;
    endtask

    // Mostly runs of one level on one switch, long enough to commit, with some
    // glitches mixed in and an occasional index outside the connected range.
    task automatic run_phase(input int n_items, input int gap, input int stall);
        int               sent;
        int               top;
        int               run_len;
        int               max_run;
        bit               clean;
        logic [IDX_W-1:0] idx;
        logic             pin;
        gap_pct   = gap;
        stall_pct = stall;
        sent      = 0;
        top       = (tracker.num_switches > NUM_SW) ? NUM_SW : tracker.num_switches;
        max_run   = (tracker.commit_level > 40) ? 300 : tracker.commit_level + 3;
        while (sent < n_items)
        begin
            if (top == 0 || $urandom_range(7) == 0)
                idx = IDX_W'($urandom_range(NUM_SW - 1));
            else
                idx = IDX_W'($urandom_range(top - 1));
            pin   = 1'($urandom_range(1));
            clean = ($urandom_range(3) == 0);
            if (clean)
                run_len = tracker.commit_level + 2;
            else
                run_len = $urandom_range(max_run, 1);
            repeat (run_len)
            begin
                if (!clean && $urandom_range(7) == 0)
                    send_sample(idx, ~pin);
                else
                    send_sample(idx, pin);
                sent++;
            end
        end
    endtask

    initial
    begin
        tracker = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: press and commit on switch 0, then a bounce that restarts
        // its run, and both levels on the top switch.
        send_sample(4'd0, 1'b1);
        repeat (5) send_sample(4'd0, 1'b1);
        send_sample(4'd0, 1'b1);
        send_sample(4'd0, 1'b0);
        send_sample(4'd0, 1'b0);
        send_sample(4'd0, 1'b1);
        send_sample(4'd0, 1'b0);
        send_sample(4'd15, 1'b1);
        send_sample(4'd15, 1'b0);

        // Fewer switches and the lowest nonzero level: index at the count is out of range.
        configure(5'd3, 8'd1);
        send_sample(4'd3, 1'b1);
        send_sample(4'd15, 1'b0);
        send_sample(4'd2, 1'b1);
        send_sample(4'd2, 1'b1);
        send_sample(4'd2, 1'b0);

        // No switches connected.
        configure(5'd0, 8'd1);
        send_sample(4'd0, 1'b1);

        configure(5'd16, 8'd5);
        run_phase(250, 0, 0);
        configure(5'd16, 8'd1);
        run_phase(250, 74, 0);
        configure(5'd7, 8'd3);
        run_phase(250, 0, 74);
        configure(5'd0, 8'd2);
        run_phase(40, 22, 22);
        configure(5'd31, 8'd0);
        run_phase(200, 22, 22);
        configure(5'd16, 8'd255);
        run_phase(450, 0, 0);
        // Switches left bouncing with long runs commit at once under a lower level.
        configure(5'd12, 8'd10);
        run_phase(200, 22, 22);

        // Long receiver hold-off while items keep coming, so the input backs up.
        configure(5'd16, 8'd2);
        hold_left <= 300;
        run_phase(150, 0, 0);
        configure(5'd5, 8'd4);
        run_phase(60, 0, 74);

        sample_valid <= 1'b0;
        while (tracker.owed.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
